// ===== hw/rtl/skip_list_sorted_multiset_defines.svh =====
// Assertion macros used by the skip list RTL
`ifndef SKIP_LIST_SORTED_MULTISET_DEFINES_SVH
`define SKIP_LIST_SORTED_MULTISET_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define SL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define SL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/sl_pkg.sv =====
// ----------------------------------------------------------------------------
// sl_pkg
// Types and constants for the skip list sorted multiset.
// ----------------------------------------------------------------------------
package sl_pkg;
  localparam int POOL_NODES  = 1024;
  localparam int LEVELS      = 16;
  localparam int KEY_BITS    = 16;
  localparam int TOTAL_NODES = POOL_NODES + 2;
  localparam int NODE_BITS   = $clog2(TOTAL_NODES);
  localparam int LVL_BITS    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int FREE_BITS   = $clog2(POOL_NODES + 1);
  localparam int LINK_DEPTH  = TOTAL_NODES * LEVELS;
  localparam int LINK_ABITS  = $clog2(LINK_DEPTH);

  localparam logic [NODE_BITS-1:0] HEAD_NODE = NODE_BITS'(0);
  localparam logic [NODE_BITS-1:0] TAIL_NODE = NODE_BITS'(1);
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] ACT_SEARCH = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_ERASE  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] key;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic pool_full;
  } rsp_t;
endpackage

// ===== hw/rtl/sl_ram.sv =====
// ----------------------------------------------------------------------------
// sl_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/skip_list_sorted_multiset.sv =====
// ----------------------------------------------------------------------------
// skip_list_sorted_multiset
// Skip list multiset in memory; search, add and erase one key per command.
// ----------------------------------------------------------------------------
// Walk: one link probe (link read, key read, compare) per level plus one per hop.
// Add: coins are drawn, then each level is linked; erase: each level is checked.
// Throughput: one command at a time; busy is high until the result cycle.
// Reset: synchronous; a clearing pass then points the head links to the tail
//   while busy stays high. Results cannot be stalled.
module skip_list_sorted_multiset (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sl_pkg::cmd_t  cmd,
  output logic          busy,
  output logic          done,
  output sl_pkg::rsp_t  rsp
);
`include "skip_list_sorted_multiset_defines.svh"

  localparam int NB = sl_pkg::NODE_BITS;
  localparam int LB = sl_pkg::LVL_BITS;
  localparam int AB = sl_pkg::LINK_ABITS;
  localparam int KB = sl_pkg::KEY_BITS;
  localparam int FB = sl_pkg::FREE_BITS;
  localparam int PB = $clog2(sl_pkg::POOL_NODES);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_ALLOC, S_FREAD, S_HEIGHT, S_LRD, S_LWAIT, S_KRD, S_KWAIT,
    S_DECIDE, S_SRES, S_INS_RD, S_INS_W1, S_INS_W2, S_ERS_PRD, S_ERS_PW,
    S_ERS_VW, S_ERS_VRD, S_ERS_FIX, S_ERS_PUSH, S_RESP
  } state_t;

  state_t state;
  logic [1:0]      act;
  logic [KB-1:0]   key;
  logic [NB-1:0]   p, nx, node;
  logic [LB-1:0]   lvl;
  logic [LB:0]     height;
  logic [NB-1:0]   path [sl_pkg::LEVELS];
  logic [FB-1:0]   free_count;
  logic [NB:0]     nodes_issued;
  logic [15:0]     lfsr;
  logic            hit, full;
  logic [NB-1:0]   pnext;

  // memory ports
  logic          l_we, k_we, f_we;
  logic [AB-1:0] l_waddr, l_raddr;
  logic [NB-1:0] l_wdata, l_rdata;
  logic [NB-1:0] k_waddr, k_raddr;
  logic [KB-1:0] k_wdata, k_rdata;
  logic [PB-1:0] f_waddr, f_raddr;
  logic [NB-1:0] f_wdata, f_rdata;

  sl_ram #(.WIDTH(NB), .DEPTH(sl_pkg::LINK_DEPTH)) u_links (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata));
  sl_ram #(.WIDTH(KB), .DEPTH(sl_pkg::TOTAL_NODES)) u_keys (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata));
  sl_ram #(.WIDTH(NB), .DEPTH(sl_pkg::POOL_NODES)) u_free (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata));

  function automatic logic [AB-1:0] laddr(logic [NB-1:0] n, logic [LB-1:0] l);
    logic [AB+LB-1:0] a;
    a = (AB+LB)'(n) * (AB+LB)'(sl_pkg::LEVELS) + (AB+LB)'(l);
    return a[AB-1:0];
  endfunction

  // memory access by state
  always_comb begin
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = laddr(p, lvl);
    k_we = 1'b0; k_waddr = node; k_wdata = key; k_raddr = nx;
    f_we = 1'b0; f_waddr = free_count[PB-1:0]; f_wdata = nx;
    f_raddr = PB'(free_count - FB'(1));
    pnext = path[lvl];
    case (state)
      S_INIT: begin
        l_we = 1'b1; l_waddr = laddr(sl_pkg::HEAD_NODE, lvl); l_wdata = sl_pkg::TAIL_NODE;
      end
      // key write for added node during first link step
      S_INS_RD: begin
        l_raddr = laddr(pnext, lvl);
        k_we = (lvl == '0);
      end
      S_INS_W1: begin
        l_we = 1'b1; l_waddr = laddr(node, lvl); l_wdata = l_rdata;
      end
      S_INS_W2: begin
        l_we = 1'b1; l_waddr = laddr(pnext, lvl); l_wdata = node;
      end
      S_ERS_PRD: l_raddr = laddr(pnext, lvl);
      S_ERS_VW:  l_raddr = laddr(nx, lvl);
      S_ERS_FIX: begin
        l_we = 1'b1; l_waddr = laddr(pnext, lvl); l_wdata = l_rdata;
      end
      S_ERS_PUSH: f_we = (free_count < FB'(sl_pkg::POOL_NODES));
      default: ;
    endcase
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; lvl <= '0; free_count <= '0;
      nodes_issued <= (NB+1)'(2); lfsr <= sl_pkg::LFSR_SEED; done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          lvl <= lvl + LB'(1);
          if (lvl == LB'(sl_pkg::LEVELS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          act <= cmd.action; key <= cmd.key[KB-1:0];
          hit <= 1'b0; full <= 1'b0; p <= sl_pkg::HEAD_NODE;
          lvl <= LB'(sl_pkg::LEVELS - 1); height <= (LB+1)'(1);
          case (cmd.action)
            sl_pkg::ACT_SEARCH, sl_pkg::ACT_ERASE: state <= S_LRD;
            sl_pkg::ACT_ADD: state <= S_ALLOC;
            default: state <= S_RESP;
          endcase
        end
        S_ALLOC: begin
          if (free_count != '0) begin
            free_count <= free_count - FB'(1); state <= S_FREAD;
          end else if (nodes_issued < (NB+1)'(sl_pkg::TOTAL_NODES)) begin
            node <= nodes_issued[NB-1:0]; nodes_issued <= nodes_issued + (NB+1)'(1);
            state <= S_HEIGHT;
          end else begin
            full <= 1'b1; state <= S_RESP;
          end
        end
        S_FREAD: begin node <= f_rdata; state <= S_HEIGHT; end
        // one coin per cycle; the losing coin is drawn too
        S_HEIGHT: begin
          lfsr <= (lfsr >> 1) ^ (lfsr[0] ? sl_pkg::LFSR_TAPS : 16'h0);
          if (lfsr[0] && height < (LB+1)'(sl_pkg::LEVELS)) height <= height + (LB+1)'(1);
          else state <= S_LRD;
        end
        S_LRD: state <= S_LWAIT;
        S_LWAIT: begin nx <= l_rdata; state <= S_KRD; end
        S_KRD: state <= S_KWAIT;
        S_KWAIT: state <= S_DECIDE;
        S_DECIDE: begin
          if (nx != sl_pkg::TAIL_NODE && k_rdata < key) begin
            p <= nx; state <= S_LRD;
          end else begin
            path[lvl] <= p;
            if (lvl != '0) begin
              lvl <= lvl - LB'(1); state <= S_LRD;
            end else begin
              case (act)
                sl_pkg::ACT_ADD: state <= S_INS_RD;
                sl_pkg::ACT_SEARCH: begin
                  hit <= (nx != sl_pkg::TAIL_NODE) && (k_rdata == key); state <= S_RESP;
                end
                default: begin
                  if (nx != sl_pkg::TAIL_NODE && k_rdata == key) begin
                    hit <= 1'b1; state <= S_ERS_PRD;
                  end else state <= S_RESP;
                end
              endcase
            end
          end
        end
        S_SRES: state <= S_RESP;
        // link new node level by level
        S_INS_RD: state <= S_INS_W1;
        S_INS_W1: state <= S_INS_W2;
        S_INS_W2: begin
          if ((LB+1)'(lvl) + (LB+1)'(1) < height) begin
            lvl <= lvl + LB'(1); state <= S_INS_RD;
          end else begin
            hit <= 1'b1; state <= S_RESP;
          end
        end
        // unlink victim (nx) at every level where predecessor points to it
        S_ERS_PRD: state <= S_ERS_PW;
        S_ERS_PW: begin
          if (l_rdata == nx) state <= S_ERS_VW; else state <= S_ERS_VRD;
        end
        S_ERS_VW: state <= S_ERS_FIX;
        S_ERS_VRD, S_ERS_FIX: begin
          if (lvl == LB'(sl_pkg::LEVELS - 1)) state <= S_ERS_PUSH;
          else begin lvl <= lvl + LB'(1); state <= S_ERS_PRD; end
        end
        S_ERS_PUSH: begin
          if (free_count < FB'(sl_pkg::POOL_NODES)) free_count <= free_count + FB'(1);
          state <= S_RESP;
        end
        S_RESP: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign rsp.hit = hit & done;
  assign rsp.pool_full = full & done;

  `SL_ASSERT_IMP(a_full_add, clk, rst, done && rsp.pool_full, act == sl_pkg::ACT_ADD,
    "pool_full outside add")
  `SL_ASSERT_NEXT(a_done_idle, clk, rst, done, state == S_IDLE || state == S_ALLOC
    || state == S_LRD || state == S_RESP, "bad state after result")
  `SL_ASSERT_IMP(a_free_bound, clk, rst, 1'b1, free_count <= FB'(sl_pkg::POOL_NODES),
    "free stack overflow")
endmodule

// ===== test/tb_skip_list_sorted_multiset.sv =====
// ----------------------------------------------------------------------------
// tb_skip_list_sorted_multiset
// Drives search, add and erase commands into the skip list multiset and
// checks every response against a behavioral multiset with the same node
// pool, free stack and level LFSR, so pool exhaustion is predicted exactly.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_skip_list_sorted_multiset;

  localparam int ROW_COUNT = 22;
  localparam int RANDOM_CMDS = 678;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic start;
  sl_pkg::cmd_t cmd;
  logic busy;
  logic done;
  sl_pkg::rsp_t rsp;

  // model state: key multiset plus pool bookkeeping
  int unsigned key_copies [logic [15:0]];
  int unsigned free_depth;
  int unsigned issued_nodes;
  logic [15:0] height_lfsr;

  sl_pkg::rsp_t resp_queue [$];
  int mismatch_count;
  int send_idle_pct;
  logic [15:0] live_keys [$];

  skip_list_sorted_multiset u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // advance the level LFSR as many coins as a new node draws
  function automatic void draw_level_coins();
    int unsigned h;
    logic bit0;
    h = 1;
    bit0 = 1'b1;
    while (bit0) begin
      bit0 = height_lfsr[0];
      height_lfsr = height_lfsr >> 1;
      if (bit0) height_lfsr = height_lfsr ^ sl_pkg::LFSR_TAPS;
      if (bit0 && h < sl_pkg::LEVELS) h++;
      else bit0 = 1'b0;
    end
  endfunction

  function automatic sl_pkg::rsp_t multiset_apply(sl_pkg::cmd_t c);
    sl_pkg::rsp_t r;
    r = '0;
    case (c.action)
      sl_pkg::ACT_SEARCH: r.hit = key_copies.exists(c.key) && key_copies[c.key] != 0;
      sl_pkg::ACT_ADD: begin
        if (free_depth > 0) free_depth--;
        else if (issued_nodes < sl_pkg::TOTAL_NODES) issued_nodes++;
        else r.pool_full = 1'b1;
        if (!r.pool_full) begin
          draw_level_coins();
          if (key_copies.exists(c.key)) key_copies[c.key]++;
          else key_copies[c.key] = 1;
          r.hit = 1'b1;
        end
      end
      sl_pkg::ACT_ERASE: begin
        if (key_copies.exists(c.key) && key_copies[c.key] != 0) begin
          key_copies[c.key]--;
          if (free_depth < sl_pkg::POOL_NODES) free_depth++;
          r.hit = 1'b1;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // one command transfer, predicted on acceptance; returns after its result
  task automatic send_cmd(sl_pkg::cmd_t c, bit has_fixed, sl_pkg::rsp_t fixed);
    sl_pkg::rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    start <= 1'b1;
    cmd <= c;
    @(posedge clk iff !busy);
    start <= 1'b0;
    pred = multiset_apply(c);
    if (has_fixed && pred != fixed) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("table row disagrees with predictor: %p vs %p", fixed, pred);
    end
    resp_queue.push_back(has_fixed ? fixed : pred);
    @(posedge clk iff done);
  endtask

  // response checker
  always @(posedge clk) begin
    sl_pkg::rsp_t want;
    if (!rst && done) begin
      if (resp_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected response %p", rsp);
      end else begin
        want = resp_queue.pop_front();
        if (rsp.hit !== want.hit || rsp.pool_full !== want.pool_full) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("response mismatch: expected hit=%0b full=%0b got hit=%0b full=%0b",
                     want.hit, want.pool_full, rsp.hit, rsp.pool_full);
        end
      end
    end
  end

  typedef struct {
    logic [1:0]  action;
    logic [15:0] key;
    bit          has_fixed;
    logic        hit;
  } stim_row_t;

  stim_row_t rows [ROW_COUNT] = '{
    '{sl_pkg::ACT_SEARCH, 16'h0000, 1, 1'b0},
    '{sl_pkg::ACT_ERASE,  16'hFFFF, 1, 1'b0},
    '{ACT_UNUSED,         16'h1234, 1, 1'b0},
    '{sl_pkg::ACT_ADD,    16'h0000, 1, 1'b1},
    '{sl_pkg::ACT_ADD,    16'hFFFF, 1, 1'b1},
    '{sl_pkg::ACT_SEARCH, 16'h0000, 1, 1'b1},
    '{sl_pkg::ACT_SEARCH, 16'hFFFF, 1, 1'b1},
    '{sl_pkg::ACT_SEARCH, 16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_ADD,    16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_ADD,    16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_ADD,    16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_ERASE,  16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_SEARCH, 16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_ERASE,  16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_ERASE,  16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_SEARCH, 16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_ERASE,  16'h8000, 0, 1'b0},
    '{sl_pkg::ACT_ADD,    16'h5555, 0, 1'b0},
    '{sl_pkg::ACT_ADD,    16'hAAAA, 0, 1'b0},
    '{ACT_UNUSED,         16'hFFFF, 1, 1'b0},
    '{sl_pkg::ACT_ERASE,  16'h0000, 1, 1'b1},
    '{sl_pkg::ACT_SEARCH, 16'h0000, 1, 1'b0}
  };

  // random command with keys drawn mostly from a small live set
  task automatic send_random_cmd(int add_pct);
    sl_pkg::cmd_t c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < add_pct) c.action = sl_pkg::ACT_ADD;
    else if (roll < add_pct + 30) c.action = sl_pkg::ACT_ERASE;
    else if (roll < 97) c.action = sl_pkg::ACT_SEARCH;
    else c.action = ACT_UNUSED;
    if (live_keys.size() > 0 && $urandom_range(3) != 0)
      c.key = live_keys[$urandom_range(live_keys.size() - 1)];
    else if ($urandom_range(1)) c.key = 16'($urandom_range(31));
    else c.key = 16'($urandom);
    if (c.action == sl_pkg::ACT_ADD && live_keys.size() < 64) live_keys.push_back(c.key);
    send_cmd(c, 0, '0);
  endtask

  initial begin
    sl_pkg::cmd_t c;
    sl_pkg::rsp_t r;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    mismatch_count = 0;
    free_depth = 0;
    issued_nodes = 2;
    height_lfsr = sl_pkg::LFSR_SEED;
    send_idle_pct = 23;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (rows[i]) begin
      c.action = rows[i].action;
      c.key = rows[i].key;
      r.hit = rows[i].hit;
      r.pool_full = 1'b0;
      send_cmd(c, rows[i].has_fixed, r);
    end

    // random phases: sender idles, then more often, then never
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      send_idle_pct = (n < 226) ? 23 : (n < 452) ? 45 : 0;
      send_random_cmd(40);
    end

    while (resp_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && resp_queue.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sl_pkg.sv
hw/rtl/sl_ram.sv
hw/rtl/skip_list_sorted_multiset.sv
test/tb_skip_list_sorted_multiset.sv
